FILE: design/supercap_power_supervisor_fsm_defines.svh
// assertion macros for the supercap power supervisor
`ifndef SUPERCAP_POWER_SUPERVISOR_FSM_DEFINES_SVH
`define SUPERCAP_POWER_SUPERVISOR_FSM_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("supervisor check failed");
// next-cycle implication, checked out of reset
`define SPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("supervisor check failed");
`else
`define SPS_ASSERT_NOW(label, ante, cons)
`define SPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: design/sps_pkg.sv
// shared types and codes of the supercap power supervisor
package sps_pkg;

  // request commands
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_WD_LIMIT = 2'd1;
  localparam logic [1:0] CMD_SHUTDOWN = 2'd2;

  // led patterns
  localparam logic [2:0] LED_POWEROFF  = 3'd0;
  localparam logic [2:0] LED_NONE      = 3'd1;
  localparam logic [2:0] LED_WATCHDOG  = 3'd2;
  localparam logic [2:0] LED_DEPLETING = 3'd3;
  localparam logic [2:0] LED_SHUTDOWN  = 3'd4;
  localparam logic [2:0] LED_REBOOT    = 3'd5;
  localparam logic [2:0] LED_SLEEP     = 3'd6;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VIN_OFF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VCAP_ON    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VCAP_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_OFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SD_WAIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REBOOT_OFF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_HOLD   = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] limit_value;
    logic [9:0]  vin_sample;
    logic [9:0]  vcap_sample;
    logic        host_off;
    logic        sleep_request;
    logic        rtc_wake;
    logic        ext_wake;
  } sps_req_t;

  typedef struct packed {
    logic [4:0] state_code;
    logic       power_enable;
    logic       bus_enable;
    logic [2:0] led_pattern;
    logic       watchdog_active;
  } sps_res_t;

  typedef struct packed {
    logic [9:0]  vin_off_level;
    logic [9:0]  vcap_on_level;
    logic [9:0]  vcap_off_level;
    logic [15:0] host_off_limit_ms;
    logic [15:0] shutdown_wait_ms;
    logic [15:0] reboot_off_ms;
    logic [15:0] off_hold_ms;
  } sps_cfg_t;

endpackage

FILE: design/sps_cfg_regs.sv
// configuration register file of the supercap power supervisor
module sps_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [15:0]                    wr_data_i,
  output sps_pkg::sps_cfg_t              cfg_o
);
  import sps_pkg::*;

  sps_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vin_off_level     <= 10'd512;
      cfg_q.vcap_on_level     <= 10'd800;
      cfg_q.vcap_off_level    <= 10'd500;
      cfg_q.host_off_limit_ms <= 16'd1000;
      cfg_q.shutdown_wait_ms  <= 16'd60000;
      cfg_q.reboot_off_ms     <= 16'd3000;
      cfg_q.off_hold_ms       <= 16'd5000;
    end else if (wr_en_i) begin
      case (wr_index_i)
        REG_VIN_OFF:    cfg_q.vin_off_level     <= wr_data_i[9:0];
        REG_VCAP_ON:    cfg_q.vcap_on_level     <= wr_data_i[9:0];
        REG_VCAP_OFF:   cfg_q.vcap_off_level    <= wr_data_i[9:0];
        REG_HOST_OFF:   cfg_q.host_off_limit_ms <= wr_data_i;
        REG_SD_WAIT:    cfg_q.shutdown_wait_ms  <= wr_data_i;
        REG_REBOOT_OFF: cfg_q.reboot_off_ms     <= wr_data_i;
        REG_OFF_HOLD:   cfg_q.off_hold_ms       <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/sps_core.sv
// sequencer state, counters and next-state logic of the supervisor
module sps_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sps_pkg::sps_req_t req_i,
  input  sps_pkg::sps_cfg_t cfg_i,
  output sps_pkg::sps_res_t res_o
);
  import sps_pkg::*;

  typedef enum logic [4:0] {
    ST_BEGIN          = 5'd0,
    ST_WAIT_VIN_ON    = 5'd1,
    ST_ENT_CHARGING   = 5'd2,
    ST_CHARGING       = 5'd3,
    ST_ENT_ON         = 5'd4,
    ST_ON             = 5'd5,
    ST_ENT_DEPLETING  = 5'd6,
    ST_DEPLETING      = 5'd7,
    ST_ENT_SHUTDOWN   = 5'd8,
    ST_SHUTDOWN       = 5'd9,
    ST_ENT_WD_REBOOT  = 5'd10,
    ST_WD_REBOOT      = 5'd11,
    ST_ENT_OFF        = 5'd12,
    ST_OFF            = 5'd13,
    ST_ENT_SLEEP_SD   = 5'd14,
    ST_SLEEP_SD       = 5'd15,
    ST_ENT_SLEEP      = 5'd16,
    ST_SLEEP          = 5'd17
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] wd_limit_q, wd_limit_d;
  logic [15:0] wd_cnt_q, wd_cnt_d;
  logic [15:0] hoff_cnt_q, hoff_cnt_d;
  logic [15:0] phase_q, phase_d;
  logic        sd_pend_q, sd_pend_d;
  logic        lim_chg_q, lim_chg_d;
  logic [2:0]  led_q, led_d;
  logic        power_q, power_d;
  logic        bus_q, bus_d;
  logic        wd_expired;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // timeouts look at the counters after this tick's increment
  assign wd_expired = (wd_limit_q != 16'd0) && (wd_cnt_d > wd_limit_q);

  always_comb begin
    state_d    = state_q;
    wd_limit_d = wd_limit_q;
    wd_cnt_d   = wd_cnt_q;
    hoff_cnt_d = hoff_cnt_q;
    phase_d    = phase_q;
    sd_pend_d  = sd_pend_q;
    lim_chg_d  = lim_chg_q;
    led_d      = led_q;
    power_d    = power_q;
    bus_d      = bus_q;
    case (req_i.command)
      CMD_TICK: begin
        wd_cnt_d   = sat_inc(wd_cnt_q);
        phase_d    = sat_inc(phase_q);
        hoff_cnt_d = req_i.host_off ? sat_inc(hoff_cnt_q) : 16'd0;
        case (state_q)
          ST_BEGIN: begin
            power_d    = 1'b0;
            bus_d      = 1'b1;
            wd_limit_d = 16'd0;
            hoff_cnt_d = 16'd0;
            led_d      = LED_POWEROFF;
            state_d    = ST_WAIT_VIN_ON;
          end
          ST_WAIT_VIN_ON: begin
            if (req_i.vin_sample >= cfg_i.vin_off_level) state_d = ST_ENT_CHARGING;
          end
          ST_ENT_CHARGING: begin
            led_d   = LED_NONE;
            state_d = ST_CHARGING;
          end
          ST_CHARGING: begin
            if (req_i.vcap_sample > cfg_i.vcap_on_level) state_d = ST_ENT_ON;
            else if (req_i.vin_sample < cfg_i.vin_off_level) state_d = ST_ENT_OFF;
          end
          ST_ENT_ON: begin
            power_d    = 1'b1;
            led_d      = LED_NONE;
            hoff_cnt_d = 16'd0;
            state_d    = ST_ON;
          end
          ST_ON: begin
            if (lim_chg_q) begin
              led_d     = (wd_limit_q != 16'd0) ? LED_WATCHDOG : LED_NONE;
              lim_chg_d = 1'b0;
            end
            if (wd_expired) state_d = ST_ENT_WD_REBOOT;
            else if (sd_pend_q) begin
              sd_pend_d = 1'b0;
              state_d   = ST_ENT_SHUTDOWN;
            end else if (req_i.sleep_request) state_d = ST_ENT_SLEEP_SD;
            else if (hoff_cnt_d > cfg_i.host_off_limit_ms) state_d = ST_ENT_OFF;
            else if (req_i.vin_sample < cfg_i.vin_off_level) state_d = ST_ENT_DEPLETING;
          end
          ST_ENT_DEPLETING: begin
            led_d   = LED_DEPLETING;
            state_d = ST_DEPLETING;
          end
          ST_DEPLETING: begin
            if (wd_expired) state_d = ST_ENT_WD_REBOOT;
            else if (sd_pend_q) begin
              sd_pend_d = 1'b0;
              state_d   = ST_ENT_SHUTDOWN;
            end else if (req_i.vin_sample > cfg_i.vin_off_level) state_d = ST_ENT_ON;
            else if (req_i.vcap_sample < cfg_i.vcap_off_level) state_d = ST_ENT_OFF;
            else if (hoff_cnt_d > cfg_i.host_off_limit_ms) state_d = ST_ENT_OFF;
          end
          ST_ENT_SHUTDOWN, ST_ENT_SLEEP_SD: begin
            led_d      = LED_SHUTDOWN;
            wd_limit_d = 16'd0;
            phase_d    = 16'd0;
            state_d    = (state_q == ST_ENT_SHUTDOWN) ? ST_SHUTDOWN : ST_SLEEP_SD;
          end
          ST_SHUTDOWN, ST_SLEEP_SD: begin
            if ((hoff_cnt_d > cfg_i.host_off_limit_ms) ||
                (phase_d > cfg_i.shutdown_wait_ms)) begin
              state_d = (state_q == ST_SHUTDOWN) ? ST_ENT_OFF : ST_ENT_SLEEP;
            end
          end
          ST_ENT_WD_REBOOT: begin
            phase_d    = 16'd0;
            wd_limit_d = 16'd0;
            bus_d      = 1'b0;
            power_d    = 1'b0;
            led_d      = LED_REBOOT;
            state_d    = ST_WD_REBOOT;
          end
          ST_WD_REBOOT: begin
            if (phase_d > cfg_i.reboot_off_ms) state_d = ST_BEGIN;
          end
          ST_ENT_OFF: begin
            bus_d   = 1'b0;
            power_d = 1'b0;
            phase_d = 16'd0;
            led_d   = LED_POWEROFF;
            state_d = ST_OFF;
          end
          ST_OFF: begin
            if (phase_d > cfg_i.off_hold_ms) state_d = ST_BEGIN;
          end
          ST_ENT_SLEEP: begin
            bus_d   = 1'b0;
            power_d = 1'b0;
            led_d   = LED_SLEEP;
            state_d = ST_SLEEP;
          end
          ST_SLEEP: begin
            if (req_i.rtc_wake || req_i.ext_wake) state_d = ST_BEGIN;
          end
          default: begin
            state_d = ST_BEGIN;
          end
        endcase
      end
      CMD_WD_LIMIT: begin
        wd_limit_d = req_i.limit_value;
        wd_cnt_d   = 16'd0;
        lim_chg_d  = 1'b1;
      end
      CMD_SHUTDOWN: begin
        sd_pend_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_BEGIN;
      wd_limit_q <= 16'd0;
      wd_cnt_q   <= 16'd0;
      hoff_cnt_q <= 16'd0;
      phase_q    <= 16'd0;
      sd_pend_q  <= 1'b0;
      lim_chg_q  <= 1'b0;
      led_q      <= LED_POWEROFF;
      power_q    <= 1'b0;
      bus_q      <= 1'b0;
    end else if (step_i) begin
      state_q    <= state_d;
      wd_limit_q <= wd_limit_d;
      wd_cnt_q   <= wd_cnt_d;
      hoff_cnt_q <= hoff_cnt_d;
      phase_q    <= phase_d;
      sd_pend_q  <= sd_pend_d;
      lim_chg_q  <= lim_chg_d;
      led_q      <= led_d;
      power_q    <= power_d;
      bus_q      <= bus_d;
    end
  end

  assign res_o.state_code      = state_q;
  assign res_o.power_enable    = power_q;
  assign res_o.bus_enable      = bus_q;
  assign res_o.led_pattern     = led_q;
  assign res_o.watchdog_active = (wd_limit_q != 16'd0);

endmodule

FILE: design/supercap_power_supervisor_fsm.sv
// top level of the supercap power supervisor
// Power sequencer for a supercapacitor-backed host supply. Each request is
// a millisecond tick (advances the 18-state sequencer by one state), a
// watchdog limit write or a shutdown request; every request gives exactly
// one result showing state, supply enable, bus enable, led pattern and
// watchdog status after that request. One request is taken every cycle
// when results are drained. A request is registered on acceptance and its
// result is offered from the sequencer registers after the single
// next-state pass between the request register and the sequencer registers.
// A result that is not taken holds the request register, and the input
// stalls only when both stages are full. The configuration port is always
// ready and must only be written while no request is in flight.
module supercap_power_supervisor_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sps_pkg::sps_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sps_pkg::sps_res_t             out_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import sps_pkg::*;

  `include "supercap_power_supervisor_fsm_defines.svh"

  // request register
  logic     in_valid_q;
  sps_req_t in_req_q;
  // result slot flag; the sequencer registers themselves hold the result
  logic     out_valid_q;
  // request moves into the sequencer when the result slot is free or being taken
  logic     advance;
  sps_cfg_t cfg;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
  end

  sps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  sps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .res_o  (out_res_o)
  );

  assign out_valid_o = out_valid_q;

  // supply only ever on with the bus up
  `SPS_ASSERT_NOW(a_power_needs_bus, out_res_o.power_enable, out_res_o.bus_enable)
  // supply on never shows the power-off pattern
  `SPS_ASSERT_NOW(a_power_led, out_res_o.power_enable, out_res_o.led_pattern != LED_POWEROFF)
  // stall only with both stages full and the result not taken
  `SPS_ASSERT_NOW(a_stall_full, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i)
  // a request that moves on always shows a result next cycle
  `SPS_ASSERT_NEXT(a_advance_result, advance, out_valid_o)

endmodule
